FILE: hw/rtl/lnds_pkg.sv
package lnds_pkg;

    // Capacity of one sequence and the widths that follow from it.
    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int LEN_W     = CNT_W;
    localparam int VALUE_W   = 32;
    localparam int ENTRY_W   = VALUE_W + LEN_W;

    // Fixed widths of the result fields.
    localparam int OUT_LEN_W = 11;
    localparam int OUT_IDX_W = 10;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_t;

    typedef struct packed {
        logic [OUT_LEN_W-1:0] best_length;
        logic [OUT_IDX_W-1:0] end_index;
        logic                 overflow;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_rd;
        logic write;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic count_zero;
        logic scan_done;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/lnds_ram.sv
module lnds_ram
#(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/lnds_ctrl.sv
module lnds_ctrl
    import lnds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.full)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (status.count_zero)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.last || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.emit = status.last && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lnds_datapath.sv
module lnds_datapath
    import lnds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_t        in_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data
);

    logic [VALUE_W-1:0] biased_reg;
    logic               last_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LEN_W-1:0]   best_reg;
    logic [ADDR_W-1:0]  best_end_reg;
    logic               ovf_reg;
    logic [ADDR_W-1:0]  scan_reg;
    logic               rd_pending_reg;
    logic [LEN_W-1:0]   prev_reg;
    logic               out_valid_reg;
    out_t               out_data_reg;

    logic [ENTRY_W-1:0] rd_entry;
    logic [VALUE_W-1:0] rd_value;
    logic [LEN_W-1:0]   rd_len;
    logic [LEN_W-1:0]   new_len;
    logic [ADDR_W-1:0]  last_addr;
    logic               full;

    // Flipping the sign bit makes unsigned order match signed order.
    lnds_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({biased_reg, new_len}),
        .re    (cmd.scan_rd),
        .raddr (scan_reg),
        .rdata (rd_entry)
    );

    assign rd_value  = rd_entry[ENTRY_W-1:LEN_W];
    assign rd_len    = rd_entry[LEN_W-1:0];
    assign new_len   = prev_reg + LEN_W'(1);
    assign last_addr = count_reg[ADDR_W-1:0] - ADDR_W'(1);
    assign full      = (count_reg == CNT_W'(MAX_ITEMS));

    assign status.full       = full;
    assign status.count_zero = (count_reg == '0);
    assign status.scan_done  = (scan_reg == last_addr);
    assign status.last       = last_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // Current item and scan of the stored entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pending_reg <= 1'b0;
            scan_reg       <= '0;
            prev_reg       <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            rd_pending_reg <= cmd.scan_rd;
            if (cmd.accept)
            begin
                scan_reg <= '0;
                prev_reg <= '0;
                last_reg <= in_data.last;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_reg <= scan_reg + ADDR_W'(1);
                end
                // Keep the largest run length among qualifying earlier values.
                if (rd_pending_reg && (rd_value <= biased_reg) && (rd_len > prev_reg))
                begin
                    prev_reg <= rd_len;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            biased_reg <= {~in_data.value[VALUE_W-1], in_data.value[VALUE_W-2:0]};
        end
    end

    // Sequence totals; a result clears them for the next sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            best_reg     <= '0;
            best_end_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (cmd.emit)
        begin
            count_reg    <= '0;
            best_reg     <= '0;
            best_end_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.accept && full)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.write)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (new_len > best_reg)
                begin
                    best_reg     <= new_len;
                    best_end_reg <= count_reg[ADDR_W-1:0];
                end
            end
        end
    end

    // Output register: holds a result until its transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.best_length <= OUT_LEN_W'(best_reg);
            out_data_reg.end_index   <= OUT_IDX_W'(best_end_reg);
            out_data_reg.overflow    <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A result never overwrites one that is still waiting.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded while output register busy");

    // Writes stay within capacity.
    a_write_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (count_reg < CNT_W'(MAX_ITEMS)))
        else $error("write beyond capacity");

    // The scan reads only entries already written in this sequence.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> ({1'b0, scan_reg} < count_reg))
        else $error("scan read past stored entries");

    // A result clears the sequence state.
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (count_reg == '0) && (best_reg == '0) && !ovf_reg)
        else $error("sequence state not cleared after result");

endmodule

FILE: hw/rtl/longest_nondecreasing_subsequence_top.sv
// Longest non-decreasing subsequence engine.
//
// Input channel (in_valid / in_ready / in_data): one signed 32-bit value per
// transaction, with a last flag that closes the sequence. Output channel
// (out_valid / out_ready / out_data): one result per sequence, carrying the
// best run length, the earliest index where such a run ends, and an overflow
// flag set when values beyond the 1024-entry capacity were dropped.
//
// Each value is compared against every stored earlier value, one read of the
// entry RAM per cycle, so a value is accepted only after the previous one has
// been scanned and written; the single RAM read port sets this pace. A value
// beyond capacity is dropped without a scan. After the last scan read the
// controller steps through drain, write and finish before loading the result.
//
// Reset clears the counters, the best run and the output valid flag; the RAM
// contents need no clearing. A stalled receiver holds the result in the
// output register while the block goes on accepting values; only a second
// result waits until the first transaction completes.
module longest_nondecreasing_subsequence_top
    import lnds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    lnds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lnds_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
